>>> rtl/vital_threshold_alert_logger_macros.svh
// Assertion macros for the vital threshold alert logger.
// Used by files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef VITAL_THRESHOLD_ALERT_LOGGER_MACROS_SVH
`define VITAL_THRESHOLD_ALERT_LOGGER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define VTAL_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define VTAL_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define VTAL_ASSERT_IMP(name, ante, cons, msg)
`define VTAL_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

>>> rtl/vtal_pkg.sv
// Shared types and constants for the vital threshold alert logger.
// No dependencies; all other RTL files but the RAM and the macro header use this package.
`timescale 1ns / 1ps

package vtal_pkg;

    localparam int LOG_DEPTH   = 20;
    localparam int FILL_W      = $clog2(LOG_DEPTH + 1);
    localparam int LOG_ADDR_W  = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int LOG_COUNT_W = 5;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 8;
    localparam int READING_W   = 8;
    localparam int STAMP_W     = 32;
    localparam int KIND_W      = 2;
    localparam int REC_W       = KIND_W + READING_W + STAMP_W;

    // reset values of the limits
    localparam logic [7:0] HR_HIGH_RST  = 8'd120;
    localparam logic [7:0] O2_LOW_RST   = 8'd92;
    localparam logic [7:0] SYS_HIGH_RST = 8'd160;
    localparam logic [7:0] SYS_LOW_RST  = 8'd90;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HR_HIGH  = 8'd0,
        CFG_O2_LOW   = 8'd1,
        CFG_SYS_HIGH = 8'd2,
        CFG_SYS_LOW  = 8'd3
    } cfg_index_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_HEART    = 2'd0,
        KIND_OXYGEN   = 2'd1,
        KIND_PRESSURE = 2'd2
    } vital_kind_t;

    // bit positions in the pending-alert mask, in emit order
    localparam int PEND_HEART    = 0;
    localparam int PEND_OXYGEN   = 1;
    localparam int PEND_PRESSURE = 2;
    localparam int PEND_W        = 3;

    typedef struct packed {
        logic [7:0] hr_high;
        logic [7:0] o2_low;
        logic [7:0] sys_high;
        logic [7:0] sys_low;
    } vtal_cfg_t;

    typedef struct packed {
        logic                 valid;
        logic [READING_W-1:0] pulse_rate;
        logic [READING_W-1:0] spo2_level;
        logic [READING_W-1:0] systolic_pressure;
        logic [STAMP_W-1:0]   sample_time;
        logic [PEND_W-1:0]    pending;
    } vtal_sample_t;

    // emitter feedback to the sample stage
    typedef struct packed {
        logic              emit;
        logic              done;
        logic [PEND_W-1:0] rest;
    } vtal_adv_t;

    typedef struct packed {
        vital_kind_t          kind;
        logic [READING_W-1:0] reading;
        logic [STAMP_W-1:0]   stamp;
    } vtal_rec_t;

    typedef struct packed {
        vital_kind_t            kind;
        logic [READING_W-1:0]   reading;
        logic [STAMP_W-1:0]     alert_time;
        logic                   logged;
        logic [LOG_COUNT_W-1:0] log_count;
        logic                   last;
    } vtal_alert_t;

endpackage

>>> rtl/vtal_if.sv
// Channel interfaces: sample input, alert output, configuration writes.
// Depends on vtal_pkg for field widths.
`timescale 1ns / 1ps

interface vtal_sample_if;
    logic                           valid;
    logic                           ready;
    logic [vtal_pkg::READING_W-1:0] pulse_rate;
    logic [vtal_pkg::READING_W-1:0] spo2_level;
    logic [vtal_pkg::READING_W-1:0] systolic_pressure;
    logic [vtal_pkg::STAMP_W-1:0]   sample_time;

    modport source (output valid, pulse_rate, spo2_level, systolic_pressure, sample_time,
                    input ready);
    modport sink   (input valid, pulse_rate, spo2_level, systolic_pressure, sample_time,
                    output ready);
endinterface

interface vtal_alert_if;
    logic                             valid;
    logic                             ready;
    logic [vtal_pkg::KIND_W-1:0]      vital_kind;
    logic [vtal_pkg::READING_W-1:0]   reading;
    logic [vtal_pkg::STAMP_W-1:0]     alert_time;
    logic                             logged;
    logic [vtal_pkg::LOG_COUNT_W-1:0] log_count;
    logic                             last;

    modport source (output valid, vital_kind, reading, alert_time, logged, log_count, last,
                    input ready);
    modport sink   (input valid, vital_kind, reading, alert_time, logged, log_count, last,
                    output ready);
endinterface

interface vtal_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [vtal_pkg::CFG_IDX_W-1:0]  index;
    logic [vtal_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/vtal_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module vtal_ram #(
    parameter int WIDTH = 42,
    parameter int DEPTH = 20
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/vtal_cfg_regs.sv
// Limit registers and their write decode.
// Depends on vtal_pkg and vtal_cfg_if.
`timescale 1ns / 1ps

module vtal_cfg_regs (
    input  logic                clk,
    input  logic                rst_n,
    vtal_cfg_if.sink            cfg,
    output vtal_pkg::vtal_cfg_t limits
);
    import vtal_pkg::*;

    vtal_cfg_t cfg_reg;
    vtal_cfg_t cfg_next;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_HR_HIGH:  cfg_next.hr_high  = cfg.data;
                CFG_O2_LOW:   cfg_next.o2_low   = cfg.data;
                CFG_SYS_HIGH: cfg_next.sys_high = cfg.data;
                CFG_SYS_LOW:  cfg_next.sys_low  = cfg.data;
                default:      cfg_next = cfg_reg;   // unknown index: ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hr_high  <= HR_HIGH_RST;
            cfg_reg.o2_low   <= O2_LOW_RST;
            cfg_reg.sys_high <= SYS_HIGH_RST;
            cfg_reg.sys_low  <= SYS_LOW_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign limits = cfg_reg;

endmodule

>>> rtl/vtal_sample_stage.sv
// Input register: captures a sample and its mask of limit breaches.
// Depends on vtal_pkg and vtal_sample_if.
`timescale 1ns / 1ps

module vtal_sample_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    vtal_sample_if.sink            sample,
    input  vtal_pkg::vtal_cfg_t    limits,
    input  vtal_pkg::vtal_adv_t    adv,
    output vtal_pkg::vtal_sample_t smp
);
    import vtal_pkg::*;

    vtal_sample_t      smp_reg;
    vtal_sample_t      smp_next;
    logic [PEND_W-1:0] breach;
    logic              accept;

    always_comb
    begin
        breach                = '0;
        breach[PEND_HEART]    = sample.pulse_rate > limits.hr_high;
        breach[PEND_OXYGEN]   = sample.spo2_level < limits.o2_low;
        breach[PEND_PRESSURE] = (sample.systolic_pressure > limits.sys_high) ||
                                (sample.systolic_pressure < limits.sys_low);
    end

    // stage frees up in the cycle its last alert leaves
    assign sample.ready = !smp_reg.valid || adv.done;
    assign accept       = sample.valid && sample.ready;

    always_comb
    begin
        smp_next = smp_reg;
        if (adv.emit)
        begin
            smp_next.pending = adv.rest;
        end
        if (adv.done)
        begin
            smp_next.valid = 1'b0;
        end
        if (accept)
        begin
            // a sample with no breach gives nothing, so it is not held
            smp_next.valid             = |breach;
            smp_next.pulse_rate        = sample.pulse_rate;
            smp_next.spo2_level        = sample.spo2_level;
            smp_next.systolic_pressure = sample.systolic_pressure;
            smp_next.sample_time       = sample.sample_time;
            smp_next.pending           = breach;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp_reg <= '0;
        end
        else
        begin
            smp_reg <= smp_next;
        end
    end

    assign smp = smp_reg;

endmodule

>>> rtl/vtal_alert_emit.sv
// Alert emitter: picks the next breach, logs it while the log has room, fills the output register.
// Depends on vtal_pkg, vtal_alert_if, vtal_ram and the assertion macros.
`timescale 1ns / 1ps
`include "vital_threshold_alert_logger_macros.svh"

module vtal_alert_emit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  vtal_pkg::vtal_sample_t smp,
    output vtal_pkg::vtal_adv_t    adv,
    vtal_alert_if.source           alert
);
    import vtal_pkg::*;

    logic              out_valid_reg;
    logic              out_valid_next;
    vtal_alert_t       out_reg;
    vtal_alert_t       res;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              emit;
    logic              full;
    logic              log_we;
    logic [PEND_W-1:0] pick;
    logic [PEND_W-1:0] rest;
    vtal_rec_t         log_wdata;
    logic [REC_W-1:0]  log_rd_data;
    logic [LOG_ADDR_W-1:0] log_addr;
    logic [LOG_ADDR_W-1:0] log_rd_addr_reg;

    // lowest pending bit goes first: heart, oxygen, pressure
    assign pick = smp.pending & (~smp.pending + 1'b1);
    assign rest = smp.pending & ~pick;

    assign emit = smp.valid && (!out_valid_reg || alert.ready);
    assign full = fill_reg >= FILL_W'(LOG_DEPTH);
    assign log_we = emit && !full;
    assign fill_next = log_we ? fill_reg + 1'b1 : fill_reg;
    assign log_addr = LOG_ADDR_W'(fill_reg);

    assign adv.emit = emit;
    assign adv.done = emit && (rest == '0);
    assign adv.rest = rest;

    always_comb
    begin
        res.alert_time = smp.sample_time;
        res.logged     = !full;
        res.log_count  = LOG_COUNT_W'(fill_next);
        res.last       = rest == '0;
        if (pick[PEND_HEART])
        begin
            res.kind    = KIND_HEART;
            res.reading = smp.pulse_rate;
        end
        else if (pick[PEND_OXYGEN])
        begin
            res.kind    = KIND_OXYGEN;
            res.reading = smp.spo2_level;
        end
        else
        begin
            res.kind    = KIND_PRESSURE;
            res.reading = smp.systolic_pressure;
        end
    end

    assign log_wdata.kind    = res.kind;
    assign log_wdata.reading = res.reading;
    assign log_wdata.stamp   = res.alert_time;

    assign out_valid_next = emit || (out_valid_reg && !alert.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            fill_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            fill_reg      <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= res;
        end
        if (log_we)
        begin
            log_rd_addr_reg <= log_addr;
        end
    end

    vtal_ram #(
        .WIDTH (REC_W),
        .DEPTH (LOG_DEPTH)
    ) u_log (
        .clk   (clk),
        .we    (log_we),
        .waddr (log_addr),
        .wdata (log_wdata),
        .raddr (log_rd_addr_reg),
        .rdata (log_rd_data)
    );

    assign alert.valid      = out_valid_reg;
    assign alert.vital_kind = out_reg.kind;
    assign alert.reading    = out_reg.reading;
    assign alert.alert_time = out_reg.alert_time;
    assign alert.logged     = out_reg.logged;
    assign alert.log_count  = out_reg.log_count;
    assign alert.last       = out_reg.last;

    `VTAL_ASSERT_NEXT(a_fill_inc, log_we, fill_reg == FILL_W'($past(fill_reg) + 1'b1), "log count did not step on a logged alert")
    `VTAL_ASSERT_NEXT(a_fill_hold, !log_we, $stable(fill_reg), "log count moved without a log write")
    `VTAL_ASSERT_IMP(a_unlogged_full, out_valid_reg && !out_reg.logged, out_reg.log_count == LOG_COUNT_W'(LOG_DEPTH), "unlogged alert while log not full")
    `VTAL_ASSERT_IMP(a_log_readback, $past(log_we, 2), log_rd_data == $past(log_wdata, 2), "log record did not read back as written")

endmodule

>>> rtl/vital_threshold_alert_logger.sv
// The first alert of a sample passes through the input register, then the output register.
// Throughput: one alert per cycle while the consumer takes them; a sample holds the input stage
//   until its last alert (of 1 to 3) moves to the emitter's single output register. No-alert
//   samples are not held. Reset: limits return to 120/92/160/90, log count to zero, all pipeline valids clear.
//   Log record contents are undefined after reset; no clearing pass.
`timescale 1ns / 1ps

// Top level of the vital threshold alert logger.
// Depends on vtal_pkg, the channel interfaces, vtal_cfg_regs, vtal_sample_stage,
// vtal_alert_emit.
module vital_threshold_alert_logger (
    input  logic         clk,
    input  logic         rst_n,
    vtal_cfg_if.sink     cfg,
    vtal_sample_if.sink  sample,
    vtal_alert_if.source alert
);
    import vtal_pkg::*;

    vtal_cfg_t    limits;   // current limit registers
    vtal_sample_t smp;      // held sample plus its remaining breaches
    vtal_adv_t    adv;      // emitter progress back to the input stage

    // Limit registers; writes take effect in the next cycle, ready is always high.
    vtal_cfg_regs u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .limits (limits)
    );

    // Input register: compares against the limits on the way in and keeps a
    // three-bit mask of breaches still to be reported. A new item enters in the
    // same cycle the last alert of the held one moves to the output register.
    vtal_sample_stage u_sample (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample),
        .limits (limits),
        .adv    (adv),
        .smp    (smp)
    );

    // Emitter: one alert per cycle, while the consumer accepts, into the output register, which doubles as
    // the skid stage toward the consumer. Logs the alert while room remains.
    vtal_alert_emit u_emit (
        .clk   (clk),
        .rst_n (rst_n),
        .smp   (smp),
        .adv   (adv),
        .alert (alert)
    );

endmodule
